// ===== sv/lpe_pkg.sv =====
// lpe_pkg: shared widths, constants and types of the line position estimator.
// No dependencies; imported by every module of the block.
`default_nettype none

package lpe_pkg;

  localparam int SENSOR_COUNT   = 5;
  localparam int SAMPLE_BITS    = 10;
  localparam int FRAC_BITS      = 12;
  localparam int MARKS_BITS     = SENSOR_COUNT * SAMPLE_BITS;
  localparam int NORM_BITS      = FRAC_BITS + 1;
  localparam int DIV_STEPS      = FRAC_BITS;
  localparam int CFG_INDEX_BITS = 2;

  // position = trunc(sum * 2^15 / (6 * 2^F)) = trunc((|sum| << POS_SHIFT) / 3), signed
  localparam int POS_BITS    = 16;
  localparam int SUM_BITS    = 16;
  localparam int POS_SHIFT   = 15 - FRAC_BITS - 1;
  localparam int MAG_BITS    = 16;
  localparam int DIV3_SHIFT  = 18;
  localparam int RECIP_BITS  = 18;
  localparam logic [RECIP_BITS-1:0] DIV3_RECIP = RECIP_BITS'(((1 << DIV3_SHIFT) + 2) / 3);
  localparam int PROD_BITS   = MAG_BITS + RECIP_BITS;

  // lane stages: load + DIV_STEPS; merge stages: 2
  localparam int PIPE_STAGES = DIV_STEPS + 3;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [NORM_BITS-1:0]   norm_t;
  typedef logic [MARKS_BITS-1:0]  marks_t;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_FULL,
    MODE_DIV
  } lane_mode_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LOW_MARKS  = 2'd0,
    CFG_HIGH_MARKS = 2'd1
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== sv/line_position_estimator_core.sv =====
// line_position_estimator_core: five lanes of pipelined dividers, merge stage,
// two-entry output buffer. Uses lpe_pkg, lpe_lane, lpe_merge.
// Pipeline: 16 register stages (load stage, 12-step divider per lane, two merge
// stages, output register), the first loaded at the transfer edge.
// Throughput: one set per cycle; the pipeline stalls only when the skid entry is full.
// Reset: low marks clear to 0, high marks to all ones, pipeline and buffer empty.
`default_nettype none

module line_position_estimator_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire [lpe_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire lpe_pkg::marks_t cfg_data_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire lpe_pkg::sample_t sample_0_i,
  input  wire lpe_pkg::sample_t sample_1_i,
  input  wire lpe_pkg::sample_t sample_2_i,
  input  wire lpe_pkg::sample_t sample_3_i,
  input  wire lpe_pkg::sample_t sample_4_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic signed [lpe_pkg::POS_BITS-1:0] position_o,
  output logic                 on_line_o
);
  import lpe_pkg::*;

  marks_t low_q, high_q;
  sample_t sample [SENSOR_COUNT];
  norm_t   norm   [SENSOR_COUNT];

  logic [PIPE_STAGES-1:0] v_q;
  logic en;

  logic signed [POS_BITS-1:0] res_pos, out_pos_q, skid_pos_q;
  logic res_on, out_on_q, skid_on_q;
  logic out_v_d, out_v_q, skid_v_d, skid_v_q;
  logic load_out, load_skid, out_from_skid, out_fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= '1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_LOW_MARKS) begin
        low_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_HIGH_MARKS) begin
        high_q <= cfg_data_i;
      end
    end
  end

  assign sample[0] = sample_0_i;
  assign sample[1] = sample_1_i;
  assign sample[2] = sample_2_i;
  assign sample[3] = sample_3_i;
  assign sample[4] = sample_4_i;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  for (genvar k = 0; k < SENSOR_COUNT; k++) begin : g_lane
    lpe_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .sample_i (sample[k]),
      .low_i    (low_q[SAMPLE_BITS*k +: SAMPLE_BITS]),
      .high_i   (high_q[SAMPLE_BITS*k +: SAMPLE_BITS]),
      .norm_o   (norm[k])
    );
  end

  lpe_merge u_merge (
    .clk_i      (clk_i),
    .en_i       (en),
    .norm_i     (norm),
    .position_o (res_pos),
    .on_line_o  (res_on)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PIPE_STAGES-2:0], in_valid_i};
    end
  end

  // output register plus skid entry
  assign out_fire = out_v_q && out_ready_i;

  always_comb begin
    out_v_d       = out_v_q;
    skid_v_d      = skid_v_q;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    if (out_fire) begin
      if (skid_v_q) begin
        out_from_skid = 1'b1;
        skid_v_d      = 1'b0;
      end else begin
        out_v_d = 1'b0;
      end
    end
    if (en && v_q[PIPE_STAGES-1]) begin
      if (out_v_d) begin
        load_skid = 1'b1;
        skid_v_d  = 1'b1;
      end else begin
        load_out = 1'b1;
        out_v_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_from_skid) begin
      out_pos_q <= skid_pos_q;
      out_on_q  <= skid_on_q;
    end else if (load_out) begin
      out_pos_q <= res_pos;
      out_on_q  <= res_on;
    end
    if (load_skid) begin
      skid_pos_q <= res_pos;
      skid_on_q  <= res_on;
    end
  end

  assign out_valid_o = out_v_q;
  assign position_o  = out_pos_q;
  assign on_line_o   = out_on_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held without a pending output");

  a_off_line_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !on_line_o) |-> (position_o == '0))
    else $error("nonzero position with on_line low");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (position_o <= 16'sd16384 && position_o >= -16'sd16384))
    else $error("position out of range");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v_q[PIPE_STAGES-1]))
    else $error("output valid without a finished item");

endmodule

`default_nettype wire

// ===== sv/lpe_lane.sv =====
// lpe_lane: one sensor lane; clamps against the calibration marks and runs a
// pipelined restoring divider, one quotient bit per stage. Uses lpe_pkg.
`default_nettype none

module lpe_lane (
  input  wire                  clk_i,
  input  wire                  en_i,
  input  wire lpe_pkg::sample_t sample_i,
  input  wire lpe_pkg::sample_t low_i,
  input  wire lpe_pkg::sample_t high_i,
  output lpe_pkg::norm_t       norm_o
);
  import lpe_pkg::*;

  sample_t             rem_q  [DIV_STEPS+1];
  sample_t             div_q  [DIV_STEPS+1];
  logic [FRAC_BITS-1:0] quo_q [DIV_STEPS+1];
  lane_mode_e          mode_q [DIV_STEPS+1];

  lane_mode_e mode_d;

  always_comb begin
    if (sample_i <= low_i) begin
      mode_d = MODE_ZERO;
    end else if (sample_i >= high_i) begin
      mode_d = MODE_FULL;
    end else begin
      mode_d = MODE_DIV;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= sample_i - low_i;
      div_q[0]  <= high_i - low_i;
      quo_q[0]  <= '0;
      mode_q[0] <= mode_d;
    end
  end

  for (genvar st = 1; st <= DIV_STEPS; st++) begin : g_step
    logic [SAMPLE_BITS+1:0] trial;
    logic                   borrow;

    assign trial  = {1'b0, rem_q[st-1], 1'b0} - {2'b00, div_q[st-1]};
    assign borrow = trial[SAMPLE_BITS+1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[st]  <= borrow ? {rem_q[st-1][SAMPLE_BITS-2:0], 1'b0} : trial[SAMPLE_BITS-1:0];
        quo_q[st]  <= {quo_q[st-1][FRAC_BITS-2:0], ~borrow};
        div_q[st]  <= div_q[st-1];
        mode_q[st] <= mode_q[st-1];
      end
    end
  end

  always_comb begin
    case (mode_q[DIV_STEPS])
      MODE_ZERO: norm_o = '0;
      MODE_FULL: norm_o = {1'b1, {FRAC_BITS{1'b0}}};
      default:   norm_o = {1'b0, quo_q[DIV_STEPS]};
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/lpe_merge.sv =====
// lpe_merge: weights and sums the lane results, then scales by 4/3 through a
// reciprocal multiply; two register stages. Uses lpe_pkg.
`default_nettype none

module lpe_merge (
  input  wire                 clk_i,
  input  wire                 en_i,
  input  wire lpe_pkg::norm_t norm_i [lpe_pkg::SENSOR_COUNT],
  output logic signed [lpe_pkg::POS_BITS-1:0] position_o,
  output logic                on_line_o
);
  import lpe_pkg::*;

  function automatic logic signed [SUM_BITS-1:0] lane_term(input int k, input norm_t n);
    logic signed [SUM_BITS-1:0] ext;
    ext = signed'({{(SUM_BITS-NORM_BITS){1'b0}}, n});
    case (k)
      0:       lane_term = -(ext <<< 1);
      1:       lane_term = -ext;
      3:       lane_term = ext;
      4:       lane_term = ext <<< 1;
      default: lane_term = '0;
    endcase
  endfunction

  logic signed [SUM_BITS-1:0] sum;
  logic [SUM_BITS-1:0]        abs_sum;
  logic [MAG_BITS-1:0]        mag_d, mag_q;
  logic [PROD_BITS-1:0]       prod_q;
  logic                       neg1_q, on1_q, neg2_q, on2_q;
  logic [POS_BITS-1:0]        quot;

  always_comb begin
    sum = '0;
    for (int k = 0; k < SENSOR_COUNT; k++) begin
      sum = sum + lane_term(k, norm_i[k]);
    end
    abs_sum = sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);
    mag_d   = MAG_BITS'(abs_sum) << POS_SHIFT;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      neg1_q <= sum[SUM_BITS-1];
      on1_q  <= (sum != '0);
      prod_q <= PROD_BITS'(mag_q) * PROD_BITS'(DIV3_RECIP);
      neg2_q <= neg1_q;
      on2_q  <= on1_q;
    end
  end

  assign quot       = prod_q[DIV3_SHIFT +: POS_BITS];
  assign position_o = neg2_q ? signed'(-quot) : signed'(quot);
  assign on_line_o  = on2_q;

endmodule

`default_nettype wire

// ===== test/line_position_estimator_core_test.sv =====
// Self-checking testbench for line_position_estimator_core: random and directed sample sets,
// with a scoreboard that predicts the weighted-centroid position and line flag of each one.
// Depends on lpe_pkg and line_position_estimator_core.
`timescale 1ns / 100ps

module line_position_estimator_core_test;
  import lpe_pkg::*;

  localparam int LATENCY = 16;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_3 = 2'd3;
  localparam sample_t SAMPLE_MAX = '1;

  typedef logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] sample_set_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] position;
    logic                       on_line;
  } line_result_t;

  class position_scoreboard;
    marks_t       low_marks;
    marks_t       high_marks;
    line_result_t expected_q[$];
    int unsigned  errors;

    function new();
      low_marks = '0;
      high_marks = '1;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] index, marks_t data);
      if (index == CFG_LOW_MARKS) begin
        low_marks = data;
      end else if (index == CFG_HIGH_MARKS) begin
        high_marks = data;
      end
    endfunction

    function int unsigned scale_sample(int unsigned s, int unsigned lo, int unsigned hi);
      if (s <= lo) return 0;
      if (s >= hi) return 1 << FRAC_BITS;
      return ((s - lo) << FRAC_BITS) / (hi - lo);
    endfunction

    function line_result_t centroid(sample_set_t s);
      int           k;
      int           sum;
      longint       scaled;
      line_result_t r;
      sum = 0;
      for (k = 0; k < SENSOR_COUNT; k++) begin
        sum += (k - 2) * int'(scale_sample(s[k], low_marks[SAMPLE_BITS*k +: SAMPLE_BITS],
                                           high_marks[SAMPLE_BITS*k +: SAMPLE_BITS]));
      end
      scaled = (longint'(sum) * 32768) / (longint'(6) << FRAC_BITS);
      if (scaled > 32767) scaled = 32767;
      if (scaled < -32768) scaled = -32768;
      r.position = scaled[POS_BITS-1:0];
      r.on_line = (sum != 0);
      return r;
    endfunction

    function void note_sample_set(sample_set_t s);
      expected_q.push_back(centroid(s));
    endfunction

    function void check_result(logic signed [POS_BITS-1:0] position, logic on_line);
      line_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result position %0d on_line %0b", $time, position, on_line);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (position !== exp_r.position) begin
        $display("%0t: position mismatch: expected %0d, actual %0d",
                 $time, exp_r.position, position);
        errors++;
      end
      if (on_line !== exp_r.on_line) begin
        $display("%0t: on_line mismatch: expected %0b, actual %0b",
                 $time, exp_r.on_line, on_line);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i = '0;
  marks_t cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sample_t sample_0_i = '0;
  sample_t sample_1_i = '0;
  sample_t sample_2_i = '0;
  sample_t sample_3_i = '0;
  sample_t sample_4_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [POS_BITS-1:0] position_o;
  logic on_line_o;

  position_scoreboard sb = new();
  int unsigned tx_idle_max = 0;
  int unsigned rx_idle_max = 0;
  bit rx_hold_req = 1'b0;
  int unsigned cycle_count = 0;

  line_position_estimator_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_0_i  (sample_0_i),
    .sample_1_i  (sample_1_i),
    .sample_2_i  (sample_2_i),
    .sample_3_i  (sample_3_i),
    .sample_4_i  (sample_4_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .position_o  (position_o),
    .on_line_o   (on_line_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** line_position_estimator_core: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_sample_set({sample_4_i, sample_3_i, sample_2_i, sample_1_i, sample_0_i});
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(position_o, on_line_o);
    end
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        stall = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else begin
        stall = $urandom_range(0, rx_idle_max);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic sample_set_t set5(sample_t a0, sample_t a1, sample_t a2,
                                       sample_t a3, sample_t a4);
    return {a4, a3, a2, a1, a0};
  endfunction

  task automatic send_set(sample_set_t s);
    int unsigned gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_0_i <= s[0];
    sample_1_i <= s[1];
    sample_2_i <= s[2];
    sample_3_i <= s[3];
    sample_4_i <= s[4];
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic drain_results();
    wait_results_done();
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, marks_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(index, data);
    @(posedge clk_i);
  endtask

  function automatic sample_t pick_sample(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 6))
      0: return sample_t'($urandom_range(0, 1023));
      1: return sample_t'(lo);
      2: return sample_t'(hi);
      3: return sample_t'($urandom_range(lo, hi));
      4: return sample_t'(lo + 1);
      5: return sample_t'(hi - 1);
      default: return $urandom_range(0, 1) ? SAMPLE_MAX : sample_t'(0);
    endcase
  endfunction

  task automatic write_random_marks();
    marks_t      lo_m;
    marks_t      hi_m;
    int unsigned lo;
    int unsigned hi;
    int          k;
    for (k = 0; k < SENSOR_COUNT; k++) begin
      case ($urandom_range(0, 9))
        6: begin lo = $urandom_range(0, 1022); hi = lo + 1; end
        7: begin lo = $urandom_range(0, 1023); hi = lo; end
        8: begin hi = $urandom_range(0, 1022); lo = $urandom_range(hi + 1, 1023); end
        9: begin lo = 0; hi = 1023; end
        default: begin lo = $urandom_range(0, 1000); hi = $urandom_range(lo + 1, 1023); end
      endcase
      lo_m[SAMPLE_BITS*k +: SAMPLE_BITS] = sample_t'(lo);
      hi_m[SAMPLE_BITS*k +: SAMPLE_BITS] = sample_t'(hi);
    end
    write_reg(CFG_LOW_MARKS, lo_m);
    write_reg(CFG_HIGH_MARKS, hi_m);
  endtask

  task automatic run_random(int unsigned n_items, int unsigned tx_max, int unsigned rx_max,
                            int unsigned pause_at);
    sample_set_t s;
    int unsigned i;
    int          k;
    tx_idle_max = tx_max;
    rx_idle_max = rx_max;
    for (i = 0; i < n_items; i++) begin
      if (i == pause_at) wait_results_done();
      for (k = 0; k < SENSOR_COUNT; k++) begin
        s[k] = pick_sample(sb.low_marks[SAMPLE_BITS*k +: SAMPLE_BITS],
                           sb.high_marks[SAMPLE_BITS*k +: SAMPLE_BITS]);
      end
      send_set(s);
    end
  endtask

  initial begin : main
    int p;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset marks: full scale on every lane
    send_set(set5(0, 0, 0, 0, 0));
    send_set(set5(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
    send_set(set5(SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0));
    send_set(set5(0, 0, 0, SAMPLE_MAX, SAMPLE_MAX));
    send_set(set5(SAMPLE_MAX, 0, 0, 0, 0));
    send_set(set5(0, 0, 0, 0, SAMPLE_MAX));
    send_set(set5(0, 0, SAMPLE_MAX, 0, 0));
    send_set(set5(10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA));
    send_set(set5(10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155));
    send_set(set5(1, 1, 1, 1, 2));
    send_set(set5(512, 0, 0, 0, 0));

    // low mark above high mark: nothing exceeds the low mark
    drain_results();
    write_reg(CFG_LOW_MARKS, '1);
    write_reg(CFG_HIGH_MARKS, '0);
    send_set(set5(SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0));
    send_set(set5(0, 0, 0, SAMPLE_MAX, 1));

    // both marks zero: any nonzero sample is full scale
    drain_results();
    write_reg(CFG_LOW_MARKS, '0);
    send_set(set5(0, 1, 0, SAMPLE_MAX, 1));

    // spare indexes must leave the marks alone
    drain_results();
    write_reg(CFG_SPARE_2, '1);
    write_reg(CFG_SPARE_3, marks_t'({$urandom, $urandom}));
    send_set(set5(5, 0, 7, 0, SAMPLE_MAX));

    // equal marks
    drain_results();
    write_reg(CFG_LOW_MARKS, {5{10'd500}});
    write_reg(CFG_HIGH_MARKS, {5{10'd500}});
    send_set(set5(499, 500, 501, 500, 499));
    send_set(set5(501, 501, 500, 499, 499));

    // one-count span per lane
    drain_results();
    write_reg(CFG_LOW_MARKS, {10'd900, 10'd700, 10'd500, 10'd300, 10'd100});
    write_reg(CFG_HIGH_MARKS, {10'd901, 10'd701, 10'd501, 10'd301, 10'd101});
    send_set(set5(101, 300, 500, 701, 900));
    send_set(set5(100, 301, 501, 700, 901));

    // wide span, samples in the interior, on the high mark and beyond both marks
    drain_results();
    write_reg(CFG_LOW_MARKS, {5{10'd10}});
    write_reg(CFG_HIGH_MARKS, {5{10'd1010}});
    send_set(set5(11, 510, 1009, 1010, 9));
    send_set(set5(1022, 600, 1, 300, 700));

    for (p = 0; p < 9; p++) begin
      drain_results();
      case (p)
        3: begin
          write_reg(CFG_LOW_MARKS, '0);
          write_reg(CFG_HIGH_MARKS, '1);
        end
        4: begin
          write_reg(CFG_LOW_MARKS, marks_t'({$urandom, $urandom}));
          write_reg(CFG_HIGH_MARKS, marks_t'({$urandom, $urandom}));
        end
        5: begin
          write_reg(CFG_LOW_MARKS, '1);
          write_reg(CFG_HIGH_MARKS, '0);
        end
        6: begin
          write_reg(CFG_LOW_MARKS, '0);
          write_reg(CFG_HIGH_MARKS, '0);
        end
        default: write_random_marks();
      endcase
      case (p)
        0: run_random(150, 11, 11, 150);
        1: run_random(150, 0, 0, 150);
        2: run_random(150, 11, 0, 150);
        3: run_random(150, 0, 11, 150);
        4: run_random(150, 11, 11, 70);
        5: run_random(60, 11, 11, 60);
        6: run_random(60, 0, 11, 60);
        7: begin
          rx_hold_req = 1'b1;
          run_random(150, 0, 11, 150);
        end
        default: run_random(100, 11, 11, 100);
      endcase
    end

    drain_results();
    if (sb.errors == 0) begin
      $display("** line_position_estimator_core: PASSED **");
    end else begin
      $display("** line_position_estimator_core: FAILED **");
    end
    $finish;
  end

endmodule
